FILE: rtl/hdf_pkg.sv
// ----------------------------------------------------------------------------
// hdf_pkg - shared definitions for the header/trailer deframer
// Byte type, configuration port widths, register indexes and the pattern
// lane helper.
// ----------------------------------------------------------------------------
package hdf_pkg;

  typedef logic [7:0] byte_t;

  // default delimiter window depth in bytes
  localparam int HDF_MAX_DELIM_BYTES = 4;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_FRAMING_ENABLE  = 3'd0;
  localparam cfg_idx_t REG_HEADER_PATTERN  = 3'd1;
  localparam cfg_idx_t REG_HEADER_LENGTH   = 3'd2;
  localparam cfg_idx_t REG_TRAILER_PATTERN = 3'd3;
  localparam cfg_idx_t REG_TRAILER_LENGTH  = 3'd4;

  // byte lane j of a 32-bit pattern, zero above lane 3
  function automatic byte_t hdf_pat_lane(logic [31:0] pat, int unsigned j);
    logic [31:0] shifted;
    shifted = pat >> (8 * j);
    return shifted[7:0];
  endfunction

endpackage

FILE: rtl/hdf_if.sv
// ----------------------------------------------------------------------------
// hdf_if - channel interfaces of the header/trailer deframer
// Received byte channel, result channel and configuration write channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------

// received byte channel
interface hdf_byte_if import hdf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// result channel
interface hdf_result_if import hdf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  logic  frame_last;

  modport source (output valid, output payload_byte, output frame_last, input ready);
  modport sink   (input valid, input payload_byte, input frame_last, output ready);
endinterface

// configuration write channel
interface hdf_cfg_if import hdf_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/header_trailer_deframer.sv
// ----------------------------------------------------------------------------
// header_trailer_deframer - delimiter based frame extractor
// A result appears in the output register in the cycle after the byte that
// releases it is accepted. One byte per cycle is taken while the output
// register is empty or being read; a stalled output register holds the input.
// Reset: synchronous, clears framing state, output valid and the
// configuration registers to their reset values.
// ----------------------------------------------------------------------------
module header_trailer_deframer import hdf_pkg::*; #(
  parameter int MAX_DELIM_BYTES = HDF_MAX_DELIM_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  hdf_byte_if.sink     in_ch,
  hdf_result_if.source out_ch,
  hdf_cfg_if.sink      cfg_ch
);

  localparam int FILL_W = $clog2(MAX_DELIM_BYTES + 1);

  typedef logic [MAX_DELIM_BYTES-1:0][7:0] win_t;
  typedef logic [FILL_W-1:0]               fill_t;

  // configuration registers
  logic        framing_en_r;
  logic [31:0] hdr_pat_r;
  logic [2:0]  hdr_len_r;
  logic [31:0] trl_pat_r;
  logic [2:0]  trl_len_r;

  // deframing state
  logic  in_frame_r, in_frame_nxt;
  win_t  hist_r, hist_nxt;
  win_t  win_r, win_nxt;
  fill_t fill_r, fill_nxt;

  // output register
  logic  out_valid_r;
  byte_t out_byte_r;
  logic  out_last_r;

  // per-request result
  logic  res_valid;
  byte_t res_byte;
  logic  res_last;

  logic  in_accept;
  byte_t data_b;

  fill_t hl, tl, tl_m1, fill_inc, fill_new;
  win_t  hist_shift, win_shift, win_new;
  logic  released;
  byte_t rel_byte;
  logic  trl_hit;
  logic [MAX_DELIM_BYTES:0] hdr_match, trl_match;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign data_b       = in_ch.data_byte;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.frame_last   = out_last_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      framing_en_r <= 1'b0;
      hdr_pat_r    <= '0;
      hdr_len_r    <= 3'd1;
      trl_pat_r    <= '0;
      trl_len_r    <= 3'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FRAMING_ENABLE:  framing_en_r <= cfg_ch.data[0];
        REG_HEADER_PATTERN:  hdr_pat_r    <= cfg_ch.data[31:0];
        REG_HEADER_LENGTH:   hdr_len_r    <= cfg_ch.data[2:0];
        REG_TRAILER_PATTERN: trl_pat_r    <= cfg_ch.data[31:0];
        REG_TRAILER_LENGTH:  trl_len_r    <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  // effective delimiter lengths, clamped to 1..max
  always_comb begin
    if (hdr_len_r == 3'd0) begin
      hl = FILL_W'(1);
    end else if (32'(hdr_len_r) > MAX_DELIM_BYTES) begin
      hl = FILL_W'(MAX_DELIM_BYTES);
    end else begin
      hl = FILL_W'(hdr_len_r);
    end
    if (trl_len_r == 3'd0) begin
      tl = FILL_W'(1);
    end else if (32'(trl_len_r) > MAX_DELIM_BYTES) begin
      tl = FILL_W'(MAX_DELIM_BYTES);
    end else begin
      tl = FILL_W'(trl_len_r);
    end
    tl_m1 = tl - FILL_W'(1);
  end

  // header history with the new byte in lane 0, saturating fill
  always_comb begin
    hist_shift    = hist_r << 8;
    hist_shift[0] = data_b;
    if (fill_r != FILL_W'(MAX_DELIM_BYTES)) begin
      fill_inc = fill_r + FILL_W'(1);
    end else begin
      fill_inc = fill_r;
    end
  end

  // trailer window: append while filling, else release oldest and shift
  always_comb begin
    win_shift = win_r >> 8;
    win_new   = win_r;
    rel_byte  = win_r[0];
    if (fill_r < tl) begin
      released = 1'b0;
      fill_new = fill_r + FILL_W'(1);
      for (int k = 0; k < MAX_DELIM_BYTES; k++) begin
        if (FILL_W'(k) == fill_r) begin
          win_new[k] = data_b;
        end
      end
    end else begin
      released = 1'b1;
      fill_new = tl;
      for (int k = 0; k < MAX_DELIM_BYTES; k++) begin
        if (FILL_W'(k) < tl_m1) begin
          win_new[k] = win_shift[k];
        end else if (FILL_W'(k) == tl_m1) begin
          win_new[k] = data_b;
        end else begin
          win_new[k] = 8'h00;
        end
      end
    end
  end

  // delimiter compare for every possible length
  always_comb begin
    hdr_match = '0;
    trl_match = '0;
    for (int l = 1; l <= MAX_DELIM_BYTES; l++) begin
      hdr_match[l] = 1'b1;
      trl_match[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (hist_shift[i] != hdf_pat_lane(hdr_pat_r, unsigned'(l - 1 - i))) begin
          hdr_match[l] = 1'b0;
        end
        if (win_new[i] != hdf_pat_lane(trl_pat_r, unsigned'(i))) begin
          trl_match[l] = 1'b0;
        end
      end
    end
    trl_hit = (fill_new == tl) && trl_match[tl];
  end

  // next state and result for one request
  always_comb begin
    in_frame_nxt = in_frame_r;
    hist_nxt     = hist_r;
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    res_valid    = 1'b0;
    res_byte     = rel_byte;
    res_last     = 1'b0;
    if (!framing_en_r) begin
      in_frame_nxt = 1'b0;
      hist_nxt     = '0;
      win_nxt      = '0;
      fill_nxt     = '0;
      res_valid    = 1'b1;
      res_byte     = data_b;
    end else if (!in_frame_r) begin
      hist_nxt = hist_shift;
      fill_nxt = fill_inc;
      if ((fill_inc >= hl) && hdr_match[hl]) begin
        in_frame_nxt = 1'b1;
        hist_nxt     = '0;
        win_nxt      = '0;
        fill_nxt     = '0;
      end
    end else begin
      win_nxt   = win_new;
      fill_nxt  = fill_new;
      res_valid = released;
      res_last  = trl_hit;
      if (trl_hit) begin
        in_frame_nxt = 1'b0;
        hist_nxt     = '0;
        win_nxt      = '0;
        fill_nxt     = '0;
      end
    end
  end

  // deframing state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      hist_r     <= '0;
      win_r      <= '0;
      fill_r     <= '0;
    end else if (in_accept) begin
      in_frame_r <= in_frame_nxt;
      hist_r     <= hist_nxt;
      win_r      <= win_nxt;
      fill_r     <= fill_nxt;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_byte_r <= res_byte;
      out_last_r <= res_last;
    end
  end

endmodule

FILE: tb/sv/header_trailer_deframer_tb.sv
// ----------------------------------------------------------------------------
// header_trailer_deframer_tb - self-checking bench for the deframer
// Sends byte streams through the received byte channel and checks every result
// against a byte-level deframing predictor kept inside the bench. Registers
// change only when the block is idle. Random phases build framed sequences with
// random content around random delimiters. Sender bursts and receiver stalls
// are random.
// ----------------------------------------------------------------------------
module header_trailer_deframer_tb;
  import hdf_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BYTES   = 1150;

  // spare index, ignored by the block
  localparam cfg_idx_t REG_SPARE = 3'd7;

  typedef enum logic [1:0] {REQ_BYTE, REQ_WRITE, REQ_PAUSE} req_kind_t;

  typedef struct packed {
    req_kind_t kind;
    byte_t     data;
    cfg_idx_t  idx;
    cfg_data_t wdata;
  } stim_req_t;

  typedef struct packed {
    byte_t payload_byte;
    logic  frame_last;
  } payload_t;

  logic clk;
  logic rst_n;

  hdf_byte_if   in_ch ();
  hdf_result_if out_ch ();
  hdf_cfg_if    cfg_ch ();

  header_trailer_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  stim_req_t stim_queue[$];
  payload_t  payload_expected[$];
  int        error_count = 0;

  // predictor copy of registers and deframing state
  logic        framing_on  = 1'b0;
  logic [31:0] hdr_pattern = '0;
  logic [2:0]  hdr_len_raw = 3'd1;
  logic [31:0] trl_pattern = '0;
  logic [2:0]  trl_len_raw = 3'd1;
  logic        frame_open  = 1'b0;
  logic [31:0] recent_bytes = '0;
  logic [31:0] held_bytes   = '0;
  int unsigned held_count   = 0;

  // stimulus generator view of the delimiters
  logic [31:0] gen_hdr_pat;
  logic [31:0] gen_trl_pat;
  int unsigned gen_hl;
  int unsigned gen_tl;
  int          queued_bytes = 0;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_length(logic [2:0] raw);
    if (raw == 3'd0) return 1;
    if (raw > HDF_MAX_DELIM_BYTES) return HDF_MAX_DELIM_BYTES;
    return raw;
  endfunction

  function automatic logic [31:0] lane_mask(int unsigned n);
    if (n >= 4) return 32'hFFFF_FFFF;
    return (32'h1 << (8 * n)) - 32'h1;
  endfunction

  function automatic void clear_deframer();
    frame_open   = 1'b0;
    recent_bytes = '0;
    held_bytes   = '0;
    held_count   = 0;
  endfunction

  function automatic void apply_register(cfg_idx_t idx, cfg_data_t wdata);
    case (idx)
      REG_FRAMING_ENABLE:  framing_on  = wdata[0];
      REG_HEADER_PATTERN:  hdr_pattern = wdata;
      REG_HEADER_LENGTH:   hdr_len_raw = wdata[2:0];
      REG_TRAILER_PATTERN: trl_pattern = wdata;
      REG_TRAILER_LENGTH:  trl_len_raw = wdata[2:0];
      default: ;
    endcase
  endfunction

  // one received byte: updates the state and queues the payload it releases
  function automatic void deframe_byte(byte_t b);
    int unsigned hl;
    int unsigned tl;
    int unsigned i;
    logic        hit;
    logic        released;
    payload_t    res;
    hl       = eff_length(hdr_len_raw);
    tl       = eff_length(trl_len_raw);
    hit      = 1'b1;
    released = 1'b0;
    res      = '0;
    if (!framing_on) begin
      // pass-through drops any frame in progress
      clear_deframer();
      res.payload_byte = b;
      payload_expected.insert(payload_expected.size(), res);
    end else if (!frame_open) begin
      // header hunt, newest byte in lane 0
      recent_bytes = {recent_bytes[23:0], b};
      if (held_count < HDF_MAX_DELIM_BYTES) held_count++;
      if (held_count >= hl) begin
        for (i = 0; i < hl; i++) begin
          if (recent_bytes[8*i +: 8] != hdr_pattern[8*(hl-1-i) +: 8]) hit = 1'b0;
        end
        if (hit) begin
          clear_deframer();
          frame_open = 1'b1;
        end
      end
    end else begin
      // hold back up to trailer length bytes, oldest in lane 0
      if (held_count < tl) begin
        held_bytes[8*held_count +: 8] = b;
        held_count++;
      end else begin
        released         = 1'b1;
        res.payload_byte = held_bytes[7:0];
        held_bytes       = ((held_bytes >> 8) & lane_mask(tl - 1)) |
                           ({24'h0, b} << (8 * (tl - 1)));
        held_count       = tl;
      end
      hit = (held_count == tl) &&
            ((held_bytes & lane_mask(tl)) == (trl_pattern & lane_mask(tl)));
      if (hit) clear_deframer();
      if (released) begin
        res.frame_last = hit;
        payload_expected.insert(payload_expected.size(), res);
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic queue_byte(input byte_t b);
    stim_req_t r;
    r      = '0;
    r.kind = REQ_BYTE;
    r.data = b;
    stim_queue.insert(stim_queue.size(), r);
    queued_bytes++;
  endtask

  task automatic queue_write(input cfg_idx_t idx, input cfg_data_t wdata);
    stim_req_t r;
    r       = '0;
    r.kind  = REQ_WRITE;
    r.idx   = idx;
    r.wdata = wdata;
    stim_queue.insert(stim_queue.size(), r);
  endtask

  task automatic queue_pause();
    stim_req_t r;
    r      = '0;
    r.kind = REQ_PAUSE;
    stim_queue.insert(stim_queue.size(), r);
  endtask

  function automatic logic [2:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 3'd0;
      1:       return 3'd7;
      2:       return 3'($urandom_range(5, 6));
      default: return 3'($urandom_range(1, 4));
    endcase
  endfunction

  // noise, header, payload, trailer; a broken frame cuts the trailer short and may cut the header short
  task automatic queue_frame(input logic broken);
    int unsigned n;
    int unsigned i;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    for (i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
    n = broken ? $urandom_range(0, gen_hl) : gen_hl;
    for (i = 0; i < n; i++) queue_byte(gen_hdr_pat[8*i +: 8]);
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
    for (i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
    n = broken ? $urandom_range(0, gen_tl - 1) : gen_tl;
    for (i = 0; i < n; i++) queue_byte(gen_trl_pat[8*i +: 8]);
  endtask

  task automatic queue_random_phase();
    logic [2:0]  hl_raw;
    logic [2:0]  tl_raw;
    logic        en;
    int unsigned frames;
    int unsigned k;
    en          = ($urandom_range(0, 5) != 0);
    hl_raw      = pick_length();
    tl_raw      = pick_length();
    gen_hdr_pat = $urandom;
    gen_trl_pat = ($urandom_range(0, 7) == 0) ? gen_hdr_pat : $urandom;
    gen_hl      = eff_length(hl_raw);
    gen_tl      = eff_length(tl_raw);
    queue_write(REG_HEADER_PATTERN, gen_hdr_pat);
    queue_write(REG_HEADER_LENGTH, ($urandom & 32'hFFFF_FFF8) | hl_raw);
    queue_write(REG_TRAILER_PATTERN, gen_trl_pat);
    queue_write(REG_TRAILER_LENGTH, ($urandom & 32'hFFFF_FFF8) | tl_raw);
    if ($urandom_range(0, 4) == 0) queue_write(REG_SPARE, $urandom);
    queue_write(REG_FRAMING_ENABLE, ($urandom & 32'hFFFF_FFFE) | en);
    frames = $urandom_range(3, 10);
    for (k = 0; k < frames; k++) begin
      case ($urandom_range(0, 9))
        0: queue_frame(1'b1);
        1: begin
          repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
        end
        default: queue_frame(1'b0);
      endcase
      if ($urandom_range(0, 19) == 0) queue_pause();
    end
  endtask

  // ---------------------------------------------------------------- driver

  logic      in_done;
  logic      cfg_done;
  stim_req_t head;
  int        gap_left    = 0;
  int        burst_left  = 1;
  int        settle_left = SETTLE_CYCLES;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      cfg_ch.valid    <= 1'b0;
      cfg_ch.index    <= '0;
      cfg_ch.data     <= '0;
    end else begin
      in_done  = in_ch.valid && in_ch.ready;
      cfg_done = cfg_ch.valid && cfg_ch.ready;
      if (in_done) begin
        deframe_byte(in_ch.data_byte);
        stim_queue.delete(0);
        settle_left = SETTLE_CYCLES;
      end
      if (cfg_done) begin
        apply_register(cfg_ch.index, cfg_ch.data);
        stim_queue.delete(0);
      end

      if (in_ch.valid && !in_done) begin
        // request held until taken
      end else if (cfg_ch.valid && !cfg_done) begin
        // register write held until taken
      end else if (stim_queue.size() == 0) begin
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b0;
      end else begin
        head = stim_queue[0];
        if (head.kind == REQ_BYTE) begin
          cfg_ch.valid <= 1'b0;
          if (gap_left > 0) begin
            gap_left--;
            in_ch.valid <= 1'b0;
          end else begin
            in_ch.valid     <= 1'b1;
            in_ch.data_byte <= head.data;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                        : $urandom_range(1, 12);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        end else begin
          // wait for the block to go idle before a write or a pause ends
          in_ch.valid <= 1'b0;
          if (payload_expected.size() != 0) settle_left = SETTLE_CYCLES;
          else if (settle_left > 0) settle_left--;
          if (settle_left == 0 && head.kind == REQ_WRITE) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= head.idx;
            cfg_ch.data  <= head.wdata;
          end else begin
            cfg_ch.valid <= 1'b0;
            if (settle_left == 0) stim_queue.delete(0);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  stall_pos     = '0;
  payload_t    want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (payload_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h last %b",
                                    out_ch.payload_byte, out_ch.frame_last));
        end else begin
          want = payload_expected.pop_front();
          if (out_ch.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %h, want %h",
                                      out_ch.payload_byte, want.payload_byte));
          if (out_ch.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last %b, want %b on byte %h",
                                      out_ch.frame_last, want.frame_last,
                                      want.payload_byte));
        end
      end
      // new stall pattern each time the position counter wraps, never all stalls
      if (stall_pos == 4'd0)
        stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      out_ch.ready <= stall_pattern[stall_pos];
      stall_pos    = stall_pos + 4'd1;
    end
  end

  // ---------------------------------------------------------------- watchdog

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("header_trailer_deframer_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n = 1'b0;

    // pass-through with reset settings
    queue_byte(8'h00);
    queue_byte(8'hFF);

    // zero header of four bytes: reset history must not match
    queue_write(REG_FRAMING_ENABLE, 32'h1);
    queue_write(REG_HEADER_PATTERN, 32'h0000_0000);
    queue_write(REG_HEADER_LENGTH, 32'h4);
    queue_write(REG_TRAILER_PATTERN, 32'hFFFF_FFFF);
    queue_write(REG_TRAILER_LENGTH, 32'h4);
    repeat (4) queue_byte(8'h00);
    queue_byte(8'h11);
    repeat (4) queue_byte(8'hFF);

    // two-byte delimiters: header inside a frame, then an empty frame
    queue_write(REG_HEADER_PATTERN, 32'h0000_817E);
    queue_write(REG_HEADER_LENGTH, 32'h2);
    queue_write(REG_TRAILER_PATTERN, 32'h0000_18E7);
    queue_write(REG_TRAILER_LENGTH, 32'h2);
    queue_byte(8'h7E); queue_byte(8'h81);
    queue_byte(8'h7E); queue_byte(8'h81);
    queue_byte(8'hE7); queue_byte(8'h18);
    queue_byte(8'h7E); queue_byte(8'h81);
    queue_byte(8'hE7); queue_byte(8'h18);

    // trailer shortened while bytes are held back
    queue_byte(8'h7E); queue_byte(8'h81);
    queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'h03);
    queue_write(REG_TRAILER_LENGTH, 32'h1);
    queue_byte(8'hE7);
    queue_pause();

    // random phases
    queued_bytes = 0;
    while (queued_bytes < RANDOM_BYTES) queue_random_phase();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_queue.size() != 0 || payload_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (payload_expected.size() != 0)
      report_mismatch($sformatf("%0d results never came", payload_expected.size()));
    if (error_count == 0) begin
      $display("header_trailer_deframer_tb passed");
    end else begin
      $display("header_trailer_deframer_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hdf_pkg.sv
rtl/hdf_if.sv
rtl/header_trailer_deframer.sv
tb/sv/header_trailer_deframer_tb.sv
